// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the letterbox strip RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/mls_pkg.sv -----
// Package for the mirrored letterbox strip block: widths, constants, command codes.
// Depends on nothing.
package mls_pkg;
    localparam int MaxSlicesLimit = 16;
    localparam logic [4:0] MaxSlicesReset = 5'd16;
    localparam int AlphaMax = 220;
    localparam int InW = 168;
    localparam int OutW = 128;
    localparam int DivW = 40;

    localparam logic [3:0] OpNone   = 4'd0;
    localparam logic [3:0] OpBar    = 4'd1;
    localparam logic [3:0] OpNe     = 4'd2;
    localparam logic [3:0] OpFe     = 4'd3;
    localparam logic [3:0] OpSn     = 4'd4;
    localparam logic [3:0] OpSf     = 4'd5;
    localparam logic [3:0] OpAlpha  = 4'd6;
    localparam logic [3:0] OpNext   = 4'd7;
    localparam logic [3:0] OpBarInc = 4'd8;

    typedef struct packed {
        logic div_start;
        logic push;
        logic [3:0] op;
    } mls_cmd_t;

    typedef struct packed {
        logic div_busy;
    } mls_sts_t;
endpackage

// ----- rtl/core/mls_div.sv -----
// Radix-2 restoring divider for unsigned operands, one quotient bit a cycle.
// Depends on mls_pkg.
`include "assert_macros.svh"
module mls_div
    import mls_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [DivW-1:0] num,
    input  logic [DivW-1:0] den,
    output logic            busy,
    output logic [DivW-1:0] quot
);
    logic [DivW-1:0] q_reg, q_next, r_reg, r_next, d_reg;
    logic [5:0] cnt_reg, cnt_next;
    logic [DivW:0] trial;
    logic [DivW:0] shifted;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        shifted = {r_reg, q_reg[DivW-1]};
        trial = shifted - {1'b0, d_reg};
        if (start) begin
            q_next = num;
            r_next = '0;
            cnt_next = 6'(DivW);
        end else if (cnt_reg != '0) begin
            if (!trial[DivW]) begin
                r_next = trial[DivW-1:0];
                q_next = {q_reg[DivW-2:0], 1'b1};
            end else begin
                r_next = shifted[DivW-1:0];
                q_next = {q_reg[DivW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) begin
            d_reg <= den;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;

    `CHK_NEXT(a_div_load, aclk, aresetn, start, cnt_reg == 6'(DivW), "divider did not load")
endmodule

// ----- rtl/core/mls_datapath.sv -----
// Datapath: request registers, bar and strip arithmetic, shared divider, result registers.
// Depends on mls_pkg and mls_div.
`include "assert_macros.svh"
module mls_datapath
    import mls_pkg::*;
#(
    parameter int MAX_SLICES_LIMIT = MaxSlicesLimit
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [InW-1:0] in_data,
    input  logic           load,
    input  logic [4:0]     max_slices,
    input  mls_cmd_t       cmd,
    output mls_sts_t       sts,
    output logic           bar_done,
    output logic           all_done,
    output logic           req_ok,
    output logic           strip_ok,
    output logic [OutW-1:0] res_data
);
    logic signed [14:0] sx_reg, sy_reg, dx_reg, dy_reg, fx_reg, fy_reg;
    logic [12:0] sw_reg, sh_reg, dw_reg, dh_reg, fw_reg, fh_reg;
    logic [1:0] bar_reg;
    logic [12:0] span_reg, n_reg, i_reg, ne_reg, fe_reg, sn_reg, sf_reg;
    logic [4:0] limit_reg;
    logic [6:0] count_reg;
    logic [OutW-1:0] res_reg, out_reg;
    logic div_start, div_busy;
    logic [DivW-1:0] div_num, div_den, quot;
    logic horiz, lead;
    logic signed [16:0] gap;
    logic [12:0] gapc, flen, slen, span, nn, sfc, slen2, dlen;
    logic [13:0] rem, twice;
    logic signed [16:0] spos, dpos, ox, oy, sxo, syo;
    logic [7:0] alpha_new;

    assign horiz = !bar_reg[1];
    assign lead = !bar_reg[0];
    assign flen = horiz ? fw_reg : fh_reg;
    assign slen = horiz ? sw_reg : sh_reg;

    always_comb begin
        unique case (bar_reg)
            2'd0: gap = 17'(fx_reg) - 17'(dx_reg);
            2'd1: gap = 17'(dx_reg) + 17'(dw_reg) - 17'(fx_reg) - 17'(fw_reg);
            2'd2: gap = 17'(fy_reg) - 17'(dy_reg);
            default: gap = 17'(dy_reg) + 17'(dh_reg) - 17'(fy_reg) - 17'(fh_reg);
        endcase
        gapc = gap[16] ? '0 : ((gap > 17'(flen)) ? flen : gap[12:0]);
        span = gapc;
        nn = (13'(limit_reg) < span) ? 13'(limit_reg) : span;
        sfc = (sf_reg < sn_reg + 13'd1) ? sn_reg + 13'd1 : sf_reg;
        slen2 = ((slen - sn_reg) < (sfc - sn_reg)) ? (slen - sn_reg) : (sfc - sn_reg);
        dlen = fe_reg - ne_reg;
        rem = 14'(span_reg) - 14'(ne_reg);
        twice = {span_reg, 1'b0} - rem;
        spos = lead ? 17'(sn_reg) : 17'(slen) - 17'(sfc);
        dpos = lead ? -17'(fe_reg) : 17'(flen) + 17'(ne_reg);
    end

    always_comb begin
        div_num = '0;
        div_den = 40'd1;
        unique case (cmd.op)
            OpNe: begin
                div_num = 40'(span_reg * i_reg);
                div_den = 40'(n_reg);
            end
            OpFe: begin
                div_num = 40'(span_reg * (i_reg + 13'd1));
                div_den = 40'(n_reg);
            end
            OpSn: begin
                div_num = 40'(slen * ne_reg);
                div_den = 40'(flen);
            end
            OpSf: begin
                div_num = 40'(slen * fe_reg);
                div_den = 40'(flen);
            end
            OpAlpha: begin
                div_num = 40'(AlphaMax) * 40'(rem * twice);
                div_den = 40'(span_reg * span_reg);
            end
            default: ;
        endcase
    end

    assign div_start = cmd.div_start;
    assign sts.div_busy = div_busy;

    mls_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .busy(div_busy), .quot(quot)
    );

    assign ox = 17'(fx_reg) + dpos;
    assign oy = 17'(fy_reg) + dpos;
    assign sxo = 17'(sx_reg) + spos;
    assign syo = 17'(sy_reg) + spos;
    assign alpha_new = (quot == '0) ? 8'd1 : quot[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            bar_reg <= '0;
        end else begin
            if (load) begin
                {fh_reg, fw_reg, fy_reg, fx_reg, dh_reg, dw_reg, dy_reg, dx_reg,
                 sh_reg, sw_reg, sy_reg, sx_reg} <= in_data;
                limit_reg <= (max_slices > 5'(MAX_SLICES_LIMIT)) ?
                    5'(MAX_SLICES_LIMIT) : max_slices;
                count_reg <= '0;
                bar_reg <= '0;
            end else if (!cmd.div_start) begin
                unique case (cmd.op)
                    OpBar: begin
                        span_reg <= span;
                        n_reg <= nn;
                        i_reg <= '0;
                    end
                    OpNe: ne_reg <= quot[12:0];
                    OpFe: fe_reg <= quot[12:0];
                    OpSn: sn_reg <= quot[12:0];
                    OpSf: sf_reg <= quot[12:0];
                    OpAlpha: begin
                        res_reg <= horiz ?
                            {4'b0, alpha_new, fh_reg, dlen, 16'(fy_reg), ox[15:0],
                             sh_reg, slen2, 16'(sy_reg), sxo[15:0]} :
                            {4'b0, alpha_new, dlen, fw_reg, oy[15:0], 16'(fx_reg),
                             slen2, sw_reg, syo[15:0], 16'(sx_reg)};
                        count_reg <= count_reg + 7'd1;
                    end
                    OpNext: i_reg <= i_reg + 13'd1;
                    OpBarInc: bar_reg <= bar_reg + 2'd1;
                    default: ;
                endcase
            end
            if (cmd.push) begin
                out_reg <= res_reg;
            end
        end
    end

    assign req_ok = (sw_reg != '0) && (sh_reg != '0) && (dw_reg != '0) && (dh_reg != '0)
        && (fw_reg != '0) && (fh_reg != '0) && (limit_reg != '0);
    assign strip_ok = (slen2 != '0) && (dlen != '0) && (count_reg < 7'd64)
        && !(slen < sn_reg) && (slen != sn_reg);
    assign bar_done = (i_reg >= n_reg);
    assign all_done = (bar_reg == 2'd3) && bar_done;
    assign res_data = out_reg;

    `CHK_IMPL(a_cnt_cap, aclk, aresetn, 1'b1, count_reg <= 7'd64, "strip count over cap")
endmodule

// ----- rtl/core/mls_ctrl.sv -----
// Controller: sequences bars, strips and divisions, and drives the result handshake.
// Depends on mls_pkg.
`include "assert_macros.svh"
module mls_ctrl
    import mls_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     load,
    output mls_cmd_t cmd,
    input  mls_sts_t sts,
    input  logic     bar_done,
    input  logic     all_done,
    input  logic     req_ok,
    input  logic     strip_ok,
    output logic     out_valid,
    output logic     out_last,
    output logic     out_none,
    input  logic     out_ready
);
    localparam logic [3:0] SIdle = 4'd0;
    localparam logic [3:0] SCheck = 4'd1;
    localparam logic [3:0] SBar = 4'd2;
    localparam logic [3:0] SDiv = 4'd3;
    localparam logic [3:0] SWait = 4'd4;
    localparam logic [3:0] SEmit = 4'd5;
    localparam logic [3:0] SNext = 4'd6;
    localparam logic [3:0] SAdv = 4'd7;
    localparam logic [3:0] SFinal = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [3:0] op_reg, op_next;
    logic pend_reg, pend_next, last_reg, last_next;
    logic ov_reg, ov_next, none_reg, none_next;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        pend_next = pend_reg;
        ov_next = ov_reg && !out_ready;
        last_next = last_reg;
        none_next = none_reg;
        cmd = '{div_start: 1'b0, push: 1'b0, op: OpNone};
        load = 1'b0;
        unique case (state_reg)
            SIdle: begin
                if (in_valid) begin
                    load = 1'b1;
                    state_next = SCheck;
                end
            end
            SCheck: begin
                state_next = req_ok ? SBar : SFinal;
            end
            SBar: begin
                cmd.op = OpBar;
                state_next = SNext;
            end
            SNext: begin
                if (!bar_done) begin
                    op_next = OpNe;
                    state_next = SDiv;
                end else if (all_done) begin
                    state_next = SFinal;
                end else begin
                    cmd.op = OpBarInc;
                    state_next = SBar;
                end
            end
            SDiv: begin
                cmd.div_start = 1'b1;
                cmd.op = op_reg;
                state_next = SWait;
            end
            SWait: begin
                if (!sts.div_busy) begin
                    if (op_reg == OpAlpha) begin
                        state_next = strip_ok ? SEmit : SAdv;
                    end else begin
                        cmd.op = op_reg;
                        case (op_reg)
                            OpNe: op_next = OpFe;
                            OpFe: op_next = OpSn;
                            OpSn: op_next = OpSf;
                            default: op_next = OpAlpha;
                        endcase
                        state_next = SDiv;
                    end
                end
            end
            SEmit: begin
                if (!(pend_reg && ov_reg && !out_ready)) begin
                    cmd.op = OpAlpha;
                    cmd.push = pend_reg;
                    if (pend_reg) begin
                        ov_next = 1'b1;
                        last_next = 1'b0;
                        none_next = 1'b0;
                    end
                    pend_next = 1'b1;
                    state_next = SAdv;
                end
            end
            SAdv: begin
                cmd.op = OpNext;
                state_next = SNext;
            end
            SFinal: begin
                if (!ov_reg || out_ready) begin
                    cmd.push = pend_reg;
                    ov_next = 1'b1;
                    last_next = 1'b1;
                    none_next = !pend_reg;
                    pend_next = 1'b0;
                    state_next = SIdle;
                end
            end
            default: state_next = SIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SIdle;
            op_reg <= OpNone;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
            last_reg <= 1'b0;
            none_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            pend_reg <= pend_next;
            ov_reg <= ov_next;
            last_reg <= last_next;
            none_reg <= none_next;
        end
    end

    assign in_ready = (state_reg == SIdle);
    assign out_valid = ov_reg;
    assign out_last = last_reg;
    assign out_none = none_reg;

    `CHK_IMPL(a_none_last, aclk, aresetn, ov_reg && none_reg, last_reg, "no_slices without last")
    `CHK_NEXT(a_hold, aclk, aresetn, ov_reg && !out_ready, ov_reg, "result dropped")
endmodule

// ----- rtl/core/mirrored_letterbox_slices_core.sv -----
// Top level of the mirrored letterbox strip block; joins controller and datapath.
// Depends on mls_pkg, mls_ctrl and mls_datapath.
// A request is accepted only while the block is idle. Each strip costs five divisions on
// one shared 40-bit radix-2 divider, plus the steps to select, emit and step on. A request
// also passes through its checks and bar changes, carries at most 64 strips, and takes
// longer while the output waits. Each strip is held back until the next one is found, so
// that the last transfer of a request can carry tlast; an empty request gives one
// transfer with tuser set.
`include "assert_macros.svh"
module mirrored_letterbox_slices_core
    import mls_pkg::*;
#(
    parameter int MAX_SLICES_LIMIT = MaxSlicesLimit
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [4:0]      cfg_wdata,
    input  logic            s_tvalid,
    output logic            s_tready,
    // src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h, fit_x, fit_y, fit_w, fit_h
    input  logic [InW-1:0]  s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // out_src_x, out_src_y, out_src_w, out_src_h, out_dst_x, out_dst_y,
    // out_dst_w, out_dst_h, fade_alpha
    output logic [OutW-1:0] m_tdata,
    output logic            m_tlast,
    // no_slices
    output logic            m_tuser
);
    logic [4:0] max_reg;
    logic load, bar_done, all_done, req_ok, strip_ok, none;
    mls_cmd_t cmd;
    mls_sts_t sts;
    logic [OutW-1:0] res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MaxSlicesReset;
        end else if (cfg_we) begin
            max_reg <= cfg_wdata;
        end
    end

    mls_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .load(load), .cmd(cmd), .sts(sts), .bar_done(bar_done), .all_done(all_done),
        .req_ok(req_ok), .strip_ok(strip_ok), .out_valid(m_tvalid), .out_last(m_tlast),
        .out_none(none), .out_ready(m_tready)
    );

    mls_datapath #(
        .MAX_SLICES_LIMIT(MAX_SLICES_LIMIT)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_data(s_tdata), .load(load),
        .max_slices(max_reg), .cmd(cmd), .sts(sts), .bar_done(bar_done),
        .all_done(all_done), .req_ok(req_ok), .strip_ok(strip_ok), .res_data(res)
    );

    assign m_tdata = none ? '0 : res;
    assign m_tuser = none;

    `CHK_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed while waiting")
endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for mirrored_letterbox_slices_core.
// Drives layout requests, predicts every strip and compares each result transfer;
// depends only on mls_pkg and the core RTL.
`timescale 1ns / 100ps
module tb;
    import mls_pkg::*;

    typedef struct packed {
        logic [12:0] fit_h;
        logic [12:0] fit_w;
        logic signed [14:0] fit_y;
        logic signed [14:0] fit_x;
        logic [12:0] dst_h;
        logic [12:0] dst_w;
        logic signed [14:0] dst_y;
        logic signed [14:0] dst_x;
        logic [12:0] src_h;
        logic [12:0] src_w;
        logic signed [14:0] src_y;
        logic signed [14:0] src_x;
    } request_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  alpha;
        logic [12:0] dh;
        logic [12:0] dw;
        logic [15:0] dy;
        logic [15:0] dx;
        logic [12:0] sh;
        logic [12:0] sw;
        logic [15:0] sy;
        logic [15:0] sx;
    } strip_data_t;

    typedef struct {
        strip_data_t d;
        logic        last;
        logic        none;
    } strip_t;

    localparam int WatchdogLimit = 40000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [InW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OutW-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    strip_t strip_q[$];
    int unsigned slice_cap = 16;
    int errors = 0;
    bit steady = 1'b0;
    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    mirrored_letterbox_slices_core DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    function automatic void predict_strips(request_t r);
        longint sx, sy, sw, sh, dx, dy, dw, dh, fx, fy, fw, fh, lim;
        longint gaps[4];
        longint gap, slen, flen, span, n, ne, fe, sn, sf, spos, slen2, dpos, dlen;
        longint rem, eased, q;
        int count;
        bit horiz, lead;
        strip_t e;
        sx = r.src_x; sy = r.src_y; sw = r.src_w; sh = r.src_h;
        dx = r.dst_x; dy = r.dst_y; dw = r.dst_w; dh = r.dst_h;
        fx = r.fit_x; fy = r.fit_y; fw = r.fit_w; fh = r.fit_h;
        lim = (slice_cap > MaxSlicesLimit) ? MaxSlicesLimit : slice_cap;
        count = 0;
        if (sw > 0 && sh > 0 && dw > 0 && dh > 0 && fw > 0 && fh > 0 && lim > 0) begin
            gaps[0] = fx - dx;
            gaps[1] = dx + dw - (fx + fw);
            gaps[2] = fy - dy;
            gaps[3] = dy + dh - (fy + fh);
            for (int bar = 0; bar < 4; bar++) begin
                horiz = bar < 2;
                lead = (bar % 2) == 0;
                gap = gaps[bar] < 0 ? 0 : gaps[bar];
                slen = horiz ? sw : sh;
                flen = horiz ? fw : fh;
                span = gap < flen ? gap : flen;
                n = lim < span ? lim : span;
                for (longint i = 0; i < n; i++) begin
                    ne = span * i / n;
                    fe = span * (i + 1) / n;
                    sn = slen * ne / flen;
                    sf = slen * fe / flen;
                    if (sf < sn + 1) sf = sn + 1;
                    spos = lead ? sn : slen - sf;
                    slen2 = (slen - sn) < (sf - sn) ? (slen - sn) : (sf - sn);
                    dpos = lead ? -fe : flen + ne;
                    dlen = fe - ne;
                    if (slen2 <= 0 || dlen <= 0 || count >= 64) continue;
                    rem = span - ne;
                    eased = rem * (2 * span - rem);
                    q = (AlphaMax * eased) / (span * span);
                    if (q < 1) q = 1;
                    e.d = '0;
                    e.last = 1'b0;
                    e.none = 1'b0;
                    e.d.alpha = q[7:0];
                    if (horiz) begin
                        e.d.sx = 16'(sx + spos); e.d.sy = 16'(sy);
                        e.d.sw = 13'(slen2);     e.d.sh = 13'(sh);
                        e.d.dx = 16'(fx + dpos); e.d.dy = 16'(fy);
                        e.d.dw = 13'(dlen);      e.d.dh = 13'(fh);
                    end else begin
                        e.d.sx = 16'(sx);        e.d.sy = 16'(sy + spos);
                        e.d.sw = 13'(sw);        e.d.sh = 13'(slen2);
                        e.d.dx = 16'(fx);        e.d.dy = 16'(fy + dpos);
                        e.d.dw = 13'(fw);        e.d.dh = 13'(dlen);
                    end
                    strip_q = {strip_q, e};
                    count++;
                end
            end
        end
        if (count == 0) begin
            e.d = '0;
            e.last = 1'b1;
            e.none = 1'b1;
            strip_q = {strip_q, e};
        end else begin
            strip_q[strip_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        strip_t e;
        strip_data_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (strip_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                e = strip_q.pop_front();
                check_field("out_src_x", e.d.sx, got.sx);
                check_field("out_src_y", e.d.sy, got.sy);
                check_field("out_src_w", e.d.sw, got.sw);
                check_field("out_src_h", e.d.sh, got.sh);
                check_field("out_dst_x", e.d.dx, got.dx);
                check_field("out_dst_y", e.d.dy, got.dy);
                check_field("out_dst_w", e.d.dw, got.dw);
                check_field("out_dst_h", e.d.dh, got.dh);
                check_field("fade_alpha", e.d.alpha, got.alpha);
                check_field("pad", 0, got.pad);
                check_field("last_slice", e.last, m_tlast);
                check_field("no_slices", e.none, m_tuser);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (s_tvalid || strip_q.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_request(request_t r);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= r;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_strips(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (strip_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_cap(int unsigned v);
        cfg_we <= 1'b1;
        cfg_wdata <= 5'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        slice_cap = v & 32'd31;
        @(posedge aclk);
    endtask

    function automatic request_t framed_request(int unsigned max_size);
        request_t r;
        int dx, dy, dw, dh, fw, fh;
        r = '0;
        r.src_x = 15'($urandom);
        r.src_y = 15'($urandom);
        r.src_w = 13'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 8191 : 60));
        r.src_h = 13'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 8191 : 60));
        dx = $urandom_range(0, 16000) - 16384;
        dy = $urandom_range(0, 16000) - 16384;
        dw = $urandom_range(1, max_size);
        dh = $urandom_range(1, max_size);
        fw = $urandom_range(1, dw);
        fh = $urandom_range(1, dh);
        r.dst_x = 15'(dx); r.dst_y = 15'(dy);
        r.dst_w = 13'(dw); r.dst_h = 13'(dh);
        r.fit_w = 13'(fw); r.fit_h = 13'(fh);
        r.fit_x = 15'(dx + $urandom_range(0, dw - fw));
        r.fit_y = 15'(dy + $urandom_range(0, dh - fh));
        if ($urandom_range(0, 5) == 0) r.fit_x = 15'(r.fit_x + $urandom_range(0, 40) - 20);
        if ($urandom_range(0, 5) == 0) r.fit_y = 15'(r.fit_y + $urandom_range(0, 40) - 20);
        return r;
    endfunction

    function automatic request_t make_request(int sx, int sy, int sw, int sh,
            int dx, int dy, int dw, int dh, int fx, int fy, int fw, int fh);
        request_t r;
        r.src_x = 15'(sx); r.src_y = 15'(sy); r.src_w = 13'(sw); r.src_h = 13'(sh);
        r.dst_x = 15'(dx); r.dst_y = 15'(dy); r.dst_w = 13'(dw); r.dst_h = 13'(dh);
        r.fit_x = 15'(fx); r.fit_y = 15'(fy); r.fit_w = 13'(fw); r.fit_h = 13'(fh);
        return r;
    endfunction

    task automatic test_directed();
        send_request(make_request(0, 0, 100, 80, 0, 0, 200, 200, 50, 60, 100, 80));
        send_request(make_request(-16384, -16384, 8191, 8191, -16384, -16384, 8191, 8191,
                                  -16384, -16384, 1, 1));
        send_request(make_request(16383, 16383, 8191, 8191, 0, 0, 8191, 8191,
                                  4000, 4000, 191, 191));
        send_request(make_request(10, 10, 0, 50, 0, 0, 100, 100, 20, 20, 50, 50));
        send_request(make_request(10, 10, 50, 0, 0, 0, 100, 100, 20, 20, 50, 50));
        send_request(make_request(10, 10, 50, 50, 0, 0, 0, 100, 20, 20, 50, 50));
        send_request(make_request(10, 10, 50, 50, 0, 0, 100, 0, 20, 20, 50, 50));
        send_request(make_request(10, 10, 50, 50, 0, 0, 100, 100, 20, 20, 0, 50));
        send_request(make_request(10, 10, 50, 50, 0, 0, 100, 100, 20, 20, 50, 0));
        send_request(make_request(5, 5, 40, 40, 0, 0, 100, 100, 0, 0, 100, 100));
        send_request(make_request(5, 5, 40, 40, 0, 0, 100, 100, -30, -30, 200, 200));
        send_request(make_request(5, 5, 40, 40, 0, 0, 100, 100, 30, 0, 70, 100));
        send_request(make_request(5, 5, 40, 40, 0, 0, 100, 100, 0, 0, 70, 100));
        send_request(make_request(5, 5, 40, 40, 0, 0, 100, 100, 0, 25, 100, 75));
        send_request(make_request(5, 5, 40, 40, 0, 0, 100, 100, 0, 0, 100, 75));
        send_request(make_request(0, 0, 3, 2, 0, 0, 400, 400, 100, 100, 200, 200));
        send_request(make_request(-7, 9, 8191, 8191, 0, 0, 40, 40, 3, 5, 7, 9));
        send_request(make_request(100, -100, 1, 1, -50, -50, 8191, 8191, 2000, 3000, 5, 3));
        send_request(make_request(0, 0, 50, 50, 0, 0, 13, 13, 4, 4, 5, 5));
        drain();
    endtask

    task automatic test_slice_limits();
        int unsigned caps[5] = '{1, 0, 31, 17, 16};
        foreach (caps[k]) begin
            write_cap(caps[k]);
            send_request(make_request(0, 0, 64, 48, 0, 0, 300, 300, 100, 90, 100, 120));
            send_request(framed_request(200));
            send_request(make_request(0, 0, 2, 2, 0, 0, 40, 40, 10, 10, 20, 20));
            drain();
        end
    endtask

    task automatic test_random_layouts();
        int unsigned caps[6] = '{16, 3, 1, 31, 8, 0};
        request_t r;
        foreach (caps[k]) begin
            write_cap((k == 4) ? $urandom_range(0, 31) : caps[k]);
            steady = (k == 2);
            for (int i = 0; i < 14; i++) begin
                if (i == 7) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (strip_q.size() != 0) @(posedge aclk);
                end
                if ($urandom_range(0, 4) == 0) begin
                    r = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                end else begin
                    r = framed_request(($urandom_range(0, 3) == 0) ? 8191 : 80);
                end
                send_request(r);
            end
            steady = 1'b0;
            drain();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_slice_limits();
        test_random_layouts();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
